>>> rtl/core/bcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants of the disk block cache directory
// Holds the directory geometry, the access codes and the structs that carry
// the lookup, the state update and the result between the modules.
// ----------------------------------------------------------------------------
package bcd_pkg;

    // Directory geometry.
    localparam int ENTRIES     = 64;
    localparam int BLOCK_BYTES = 512;
    localparam int SLOT_W      = $clog2(ENTRIES);
    localparam int FILL_W      = $clog2(ENTRIES + 1);

    // Field widths of one access beat and one result beat.
    localparam int SECTOR_W = 32;
    localparam int OFFSET_W = 9;
    localparam int COUNT_W  = 10;

    // Access kinds.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // What the directory sees for the sector under lookup.
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   hit_slot;
        logic                full;
        logic [SLOT_W-1:0]   free_slot;
        logic [SECTOR_W-1:0] victim_tag;
        logic                victim_dirty;
    } lookup_t;

    // Change to apply to the directory for one access.
    typedef struct packed {
        logic                set_dirty;
        logic                allocate;
        logic                bump_fill;
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] tag;
    } update_t;

    // One result beat.
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                fill_from_disk;
        logic                writeback_victim;
        logic [SECTOR_W-1:0] victim_sector;
        logic                write_through;
    } result_t;

endpackage

>>> rtl/core/bcd_dir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_dir: tag store and associative match
// Keeps valid, dirty and tag bits for every slot plus the fill count,
// compares the sector against all valid tags at once and applies updates.
// ----------------------------------------------------------------------------
module bcd_dir (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bcd_pkg::SECTOR_W-1:0]     sector,
    input  logic                             upd_en,
    input  bcd_pkg::update_t                 upd,
    output bcd_pkg::lookup_t                 lookup
);
    import bcd_pkg::*;

    logic                valid_reg [ENTRIES];
    logic                dirty_reg [ENTRIES];
    logic [SECTOR_W-1:0] tag_reg   [ENTRIES];
    logic [FILL_W-1:0]   filled_reg;
    logic [ENTRIES-1:0]  match;
    logic [SLOT_W-1:0]   hit_slot;

    // Compare the sector against every valid tag in parallel.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == sector);
        end
    end

    // A sector sits in at most one slot, so the slot number is an OR of matches.
    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
            begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        lookup.hit          = |match;
        lookup.hit_slot     = hit_slot;
        lookup.full         = (filled_reg == FILL_W'(ENTRIES));
        lookup.free_slot    = filled_reg[SLOT_W-1:0];
        lookup.victim_tag   = tag_reg[0];
        lookup.victim_dirty = dirty_reg[0];
    end

    // Valid and dirty bits and the fill count are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
            end
            filled_reg <= '0;
        end
        else if (upd_en)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (upd.slot == SLOT_W'(i))
                begin
                    if (upd.allocate)
                    begin
                        valid_reg[i] <= 1'b1;
                        dirty_reg[i] <= 1'b0;
                    end
                    else if (upd.set_dirty)
                    begin
                        dirty_reg[i] <= 1'b1;
                    end
                end
            end
            if (upd.bump_fill)
            begin
                filled_reg <= filled_reg + FILL_W'(1);
            end
        end
    end

    // Tags hold no reset value; a tag is only looked at behind its valid bit.
    always_ff @(posedge clk)
    begin
        if (upd_en && upd.allocate)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (upd.slot == SLOT_W'(i))
                begin
                    tag_reg[i] <= upd.tag;
                end
            end
        end
    end

endmodule

>>> rtl/core/bcd_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_decide: access decision logic
// Turns the lookup of one access into the slot choice, the disk actions
// reported in the result and the change to make in the directory.
// ----------------------------------------------------------------------------
module bcd_decide (
    input  logic                             cmd,
    input  logic [bcd_pkg::SECTOR_W-1:0]     sector,
    input  logic [bcd_pkg::OFFSET_W-1:0]     byte_offset,
    input  logic [bcd_pkg::COUNT_W-1:0]      byte_count,
    input  bcd_pkg::lookup_t                 lookup,
    output bcd_pkg::update_t                 upd,
    output bcd_pkg::result_t                 res
);
    import bcd_pkg::*;

    logic is_write;
    logic whole_block;
    logic evict;
    logic miss;

    assign is_write    = (cmd == CMD_WRITE);
    assign whole_block = (byte_offset == '0) && (32'(byte_count) >= 32'(BLOCK_BYTES));
    assign miss        = !lookup.hit;
    assign evict       = miss && lookup.full;

    // Directory change: hits only mark dirty on write; misses take a slot.
    always_comb
    begin
        upd.set_dirty = lookup.hit && is_write;
        upd.allocate  = miss;
        upd.bump_fill = miss && !lookup.full;
        upd.tag       = sector;
        if (lookup.hit)
        begin
            upd.slot = lookup.hit_slot;
        end
        else if (lookup.full)
        begin
            upd.slot = '0;
        end
        else
        begin
            upd.slot = lookup.free_slot;
        end
    end

    // Result beat: a write miss skips the fill only for a whole-block write.
    always_comb
    begin
        res.hit              = lookup.hit;
        res.slot             = upd.slot;
        res.fill_from_disk   = miss && !(is_write && whole_block);
        res.writeback_victim = evict && lookup.victim_dirty;
        res.victim_sector    = evict ? lookup.victim_tag : '0;
        res.write_through    = miss && is_write;
    end

endmodule

>>> rtl/core/disk_block_cache_directory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_block_cache_directory: tag directory of a fully associative disk cache
// Matches each access against 64 slot tags, allocates or evicts a slot and
// reports the disk actions that the access requires.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Beat contents
//  access    start / busy        cmd, sector, byte_offset, byte_count
//  result    done (strobe)       hit, slot, fill_from_disk, writeback_victim,
//                                victim_sector, write_through
//
//  An access beat is registered at the accepting edge, looked up and applied
//  to the directory in the following cycle, and its result beat is registered
//  from that lookup and shows for one cycle. busy stays low: one access per
//  cycle is taken, the directory update landing in time for the next lookup.
//  Reset clears all valid and dirty bits and the fill count at once.
//  The receiver cannot stall; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module disk_block_cache_directory (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             cmd,
    input  logic [bcd_pkg::SECTOR_W-1:0]     sector,
    input  logic [bcd_pkg::OFFSET_W-1:0]     byte_offset,
    input  logic [bcd_pkg::COUNT_W-1:0]      byte_count,
    output logic                             done,
    output logic                             hit,
    output logic [bcd_pkg::SLOT_W-1:0]       slot,
    output logic                             fill_from_disk,
    output logic                             writeback_victim,
    output logic [bcd_pkg::SECTOR_W-1:0]     victim_sector,
    output logic                             write_through
);
    import bcd_pkg::*;

    logic                in_valid_reg;
    logic                cmd_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                done_reg;
    result_t             res_reg;
    result_t             res_next;
    update_t             upd;
    lookup_t             lookup;
    logic                accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            sector_reg <= sector;
            offset_reg <= byte_offset;
            count_reg  <= byte_count;
        end
    end

    // Tag store and match.
    bcd_dir u_dir (
        .clk    (clk),
        .rst_n  (rst_n),
        .sector (sector_reg),
        .upd_en (in_valid_reg),
        .upd    (upd),
        .lookup (lookup)
    );

    // Slot choice and disk actions.
    bcd_decide u_decide (
        .cmd         (cmd_reg),
        .sector      (sector_reg),
        .byte_offset (offset_reg),
        .byte_count  (count_reg),
        .lookup      (lookup),
        .upd         (upd),
        .res         (res_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done             = done_reg;
    assign hit              = res_reg.hit;
    assign slot             = res_reg.slot;
    assign fill_from_disk   = res_reg.fill_from_disk;
    assign writeback_victim = res_reg.writeback_victim;
    assign victim_sector    = res_reg.victim_sector;
    assign write_through    = res_reg.write_through;

endmodule

>>> rtl/core/bcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_checker: port-level checks of the disk block cache directory
// Watches the access and result ports and checks latency and the
// consistency of the reported disk actions.
// ----------------------------------------------------------------------------
module bcd_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             done,
    input  logic                             hit,
    input  logic [bcd_pkg::SLOT_W-1:0]       slot,
    input  logic                             fill_from_disk,
    input  logic                             writeback_victim,
    input  logic [bcd_pkg::SECTOR_W-1:0]     victim_sector,
    input  logic                             write_through
);
    import bcd_pkg::*;

    // Every accepted access beat yields a result beat through the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result beat missing two cycles after an access beat");

    // No result beat appears without a matching earlier access beat.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result beat without a matching access beat");

    // A hit never asks for any disk traffic.
    a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!fill_from_disk && !writeback_victim
                           && !write_through && victim_sector == '0))
        else $error("hit reported with disk actions");

    // A miss always needs a fill or a write-through.
    a_miss_action: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (fill_from_disk || write_through))
        else $error("miss reported with no disk action");

    // Write-back only happens on an eviction, which always hits slot zero.
    a_victim_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && writeback_victim) |-> (!hit && slot == '0))
        else $error("write-back reported outside an eviction of slot zero");

endmodule

bind disk_block_cache_directory bcd_checker u_bcd_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the disk block cache directory
// Sends directed and random read and write accesses, predicts the slot, hit
// and disk actions of every access with a local copy of the directory, and
// compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;

    import bcd_pkg::*;

    // Directory model and store of predicted result beats.
    class slot_scoreboard;
        bit                  slot_valid [ENTRIES];
        logic [SECTOR_W-1:0] slot_tag   [ENTRIES];
        bit                  slot_dirty [ENTRIES];
        int unsigned         slots_used;
        result_t             expected_beats [$];
        int unsigned         errors;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_tag[i]   = '0;
                slot_dirty[i] = 1'b0;
            end
            slots_used = 0;
            errors     = 0;
        endfunction

        // Works out the result of one accepted access and updates the directory.
        function void note_access(logic acc_cmd, logic [SECTOR_W-1:0] sec,
                                  logic [OFFSET_W-1:0] ofs, logic [COUNT_W-1:0] cnt);
            result_t r;
            int      found;
            r     = '0;
            found = -1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (found < 0 && slot_valid[i] && slot_tag[i] == sec)
                    found = i;
            end
            if (found >= 0)
            begin
                // Hit: only a write changes anything, by marking the slot dirty.
                r.hit  = 1'b1;
                r.slot = SLOT_W'(found);
                if (acc_cmd == CMD_WRITE)
                    slot_dirty[found] = 1'b1;
            end
            else
            begin
                // Miss: take the next free slot, or evict slot 0 once full.
                if (slots_used < ENTRIES)
                begin
                    r.slot = SLOT_W'(slots_used);
                    slots_used++;
                end
                else
                begin
                    r.slot             = '0;
                    r.victim_sector    = slot_tag[0];
                    r.writeback_victim = slot_dirty[0];
                end
                slot_valid[r.slot] = 1'b1;
                slot_tag[r.slot]   = sec;
                slot_dirty[r.slot] = 1'b0;
                if (acc_cmd == CMD_WRITE)
                begin
                    r.fill_from_disk = !(ofs == 0 && cnt >= BLOCK_BYTES);
                    r.write_through  = 1'b1;
                end
                else
                begin
                    r.fill_from_disk = 1'b1;
                end
            end
            expected_beats.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_val,
                                    logic [31:0] act_val);
            if (act_val !== exp_val)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        // Checks one result beat against the oldest prediction.
        function void check_beat(logic r_hit, logic [SLOT_W-1:0] r_slot, logic r_fill,
                                 logic r_wb, logic [SECTOR_W-1:0] r_victim,
                                 logic r_wt);
            result_t e;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with no access outstanding");
                errors++;
            end
            else
            begin
                e = expected_beats.pop_front();
                compare_field("hit", e.hit, r_hit);
                compare_field("slot", e.slot, r_slot);
                compare_field("fill_from_disk", e.fill_from_disk, r_fill);
                compare_field("writeback_victim", e.writeback_victim, r_wb);
                compare_field("victim_sector", e.victim_sector, r_victim);
                compare_field("write_through", e.write_through, r_wt);
            end
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction
    endclass

    localparam int SECTOR_POOL = 96;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                cmd;
    logic [SECTOR_W-1:0] sector;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  byte_count;
    logic                done;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                fill_from_disk;
    logic                writeback_victim;
    logic [SECTOR_W-1:0] victim_sector;
    logic                write_through;

    slot_scoreboard      sb = new();
    int unsigned         idle_pct;
    logic [SECTOR_W-1:0] sector_pool [SECTOR_POOL];
    logic [SECTOR_W-1:0] last_sector;

    disk_block_cache_directory u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd),
        .sector           (sector),
        .byte_offset      (byte_offset),
        .byte_count       (byte_count),
        .done             (done),
        .hit              (hit),
        .slot             (slot),
        .fill_from_disk   (fill_from_disk),
        .writeback_victim (writeback_victim),
        .victim_sector    (victim_sector),
        .write_through    (write_through)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // Monitor: note accepted access beats and check result beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_access(cmd, sector, byte_offset, byte_count);
            if (done)
                sb.check_beat(hit, slot, fill_from_disk, writeback_victim,
                              victim_sector, write_through);
        end
    end

    // Sends one access beat after a random idle gap, returning at acceptance.
    task automatic send_access(logic acc_cmd, logic [SECTOR_W-1:0] sec,
                               logic [OFFSET_W-1:0] ofs, logic [COUNT_W-1:0] cnt);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= acc_cmd;
        sector      <= sec;
        byte_offset <= ofs;
        byte_count  <= cnt;
        last_sector  = sec;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Draws one random access, mostly from a pool of sectors so that hits
    // and evictions both happen often.
    task automatic send_random_access();
        logic [SECTOR_W-1:0] sec;
        logic [OFFSET_W-1:0] ofs;
        logic [COUNT_W-1:0]  cnt;
        int unsigned         pick;
        pick = $urandom_range(99);
        if (pick < 15)
            sec = last_sector;
        else if (pick < 85)
            sec = sector_pool[$urandom_range(SECTOR_POOL - 1)];
        else
            sec = $urandom;
        case ($urandom_range(3))
            0:       ofs = '0;
            1:       ofs = OFFSET_W'(BLOCK_BYTES - 1);
            default: ofs = OFFSET_W'($urandom_range(BLOCK_BYTES - 1));
        endcase
        case ($urandom_range(4))
            0:       cnt = COUNT_W'(BLOCK_BYTES);
            1:       cnt = COUNT_W'($urandom_range(1023, BLOCK_BYTES + 1));
            2:       cnt = '0;
            default: cnt = COUNT_W'($urandom_range(1023));
        endcase
        send_access($urandom_range(1) ? CMD_WRITE : CMD_READ, sec, ofs, cnt);
    endtask

    // Holds the sender off until every predicted beat has arrived. The first
    // edge lets the monitor note the beat accepted at the calling edge.
    task automatic wait_drained();
        int unsigned cycles;
        cycles = 0;
        start <= 1'b0;
        @(posedge clk);
        cycles++;
        while (sb.pending() != 0 && cycles < 1000)
        begin
            @(posedge clk);
            cycles++;
        end
        if (sb.pending() != 0)
        begin
            $error("%0d result beats never arrived", sb.pending());
            sb.errors++;
        end
    endtask

    // Stimulus.
    initial
    begin
        int unsigned phase_pct [4];
        phase_pct[0] = 0;
        phase_pct[1] = 68;
        phase_pct[2] = 0;
        phase_pct[3] = 6;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= CMD_READ;
        sector      <= '0;
        byte_offset <= '0;
        byte_count  <= '0;
        idle_pct     = 0;
        last_sector  = '0;
        for (int i = 0; i < SECTOR_POOL; i++)
            sector_pool[i] = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: hits and misses of both kinds, whole and partial
        // block writes, and extreme sectors, offsets and counts.
        send_access(CMD_READ, '0, '0, '0);
        send_access(CMD_READ, '0, '0, COUNT_W'(BLOCK_BYTES));
        send_access(CMD_WRITE, '0, OFFSET_W'(BLOCK_BYTES - 1), 10'd1);
        send_access(CMD_WRITE, 32'hFFFF_FFFF, '0, COUNT_W'(BLOCK_BYTES));
        send_access(CMD_WRITE, 32'h0000_0001, '0, 10'h3FF);
        send_access(CMD_WRITE, 32'h0000_0002, 9'd1, COUNT_W'(BLOCK_BYTES));
        send_access(CMD_WRITE, 32'h0000_0003, OFFSET_W'(BLOCK_BYTES - 1), 10'h3FF);
        send_access(CMD_WRITE, 32'h0000_0004, '0, COUNT_W'(BLOCK_BYTES - 1));
        send_access(CMD_WRITE, 32'h0000_0005, '0, '0);
        send_access(CMD_READ, 32'h8000_0000, OFFSET_W'(BLOCK_BYTES - 1), 10'h3FF);
        send_access(CMD_READ, 32'hFFFF_FFFF, 9'h155, 10'h2AA);
        send_access(CMD_WRITE, 32'hFFFF_FFFF, 9'h0AA, 10'h155);
        send_access(CMD_READ, 32'h0000_0005, '0, COUNT_W'(BLOCK_BYTES));
        send_access(CMD_READ, 32'h5555_5555, '0, COUNT_W'(BLOCK_BYTES + 1));
        send_access(CMD_WRITE, 32'hAAAA_AAAA, '0, COUNT_W'(BLOCK_BYTES + 1));
        wait_drained();

        // Random part in phases of sender idling, draining between phases.
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_pct[p];
            repeat (334)
                send_random_access();
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
